// ----- hw/rtl/hdlc_dfr_pkg.sv -----
// HDLC deframer package: widths, byte codes, event codes, register indexes
// and the state, config and result structs shared by all deframer files.
// No dependencies.
`timescale 1ns / 1ps

package hdlc_dfr_pkg;

    localparam int COUNT_W = 12;               // payload byte counter width
    localparam int LEN_W   = 12;               // frame_length / frame_limit width
    localparam int CMP_W   = 17;               // wider than the counter and length widths
    localparam int IDX_W   = 1;                // config register index width

    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_W) - 64'd1);

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_XOR   = 8'h20;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 12'd508;

    localparam logic [1:0] EV_DATA    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_ABORT   = 2'd2;
    localparam logic [1:0] EV_DISCARD = 2'd3;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    localparam logic [IDX_W-1:0] REG_FRAME_LIMIT = 1'd0;
    localparam logic [IDX_W-1:0] REG_SINK        = 1'd1;

    typedef struct packed {
        logic               in_frame;
        logic               esc;
        logic [COUNT_W-1:0] count;
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0] frame_limit;
        logic             sink_attached;
    } t_cfg;

    typedef struct packed {
        logic             valid;
        logic [1:0]       event_res;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] frame_length;
    } t_result;

endpackage

// ----- hw/rtl/hdlc_dfr_ifs.sv -----
// HDLC deframer channel interfaces: line byte input, event output and
// configuration write channel. Depends on hdlc_dfr_pkg.
`timescale 1ns / 1ps

interface hdlc_dfr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] line_byte;

    modport source (output valid, output kind, output line_byte, input ready);
    modport sink   (input valid, input kind, input line_byte, output ready);
endinterface

interface hdlc_dfr_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       event_res;
    logic [7:0]                       payload_byte;
    logic [hdlc_dfr_pkg::LEN_W-1:0]   frame_length;

    modport source (output valid, output event_res, output payload_byte,
                    output frame_length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input frame_length, output ready);
endinterface

interface hdlc_dfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hdlc_dfr_pkg::IDX_W-1:0]   index;
    logic [hdlc_dfr_pkg::LEN_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/hdlc_dfr_step.sv -----
// HDLC deframer per-byte step: unstuffing, frame open/close and length limit.
// Pure combinational; depends on hdlc_dfr_pkg.
`timescale 1ns / 1ps

module hdlc_dfr_step (
    input  logic                 i_kind,
    input  logic [7:0]           i_line_byte,
    input  hdlc_dfr_pkg::t_state i_state,
    input  hdlc_dfr_pkg::t_cfg   i_cfg,
    output hdlc_dfr_pkg::t_state o_state,
    output hdlc_dfr_pkg::t_result o_result
);

    logic [hdlc_dfr_pkg::CMP_W-1:0] limit_ext;
    logic [hdlc_dfr_pkg::CMP_W-1:0] limit_sat;
    logic [hdlc_dfr_pkg::CMP_W-1:0] count_ext;
    logic [7:0]                     data_byte;

    assign limit_ext = hdlc_dfr_pkg::CMP_W'(i_cfg.frame_limit);
    assign limit_sat = (limit_ext > hdlc_dfr_pkg::COUNT_MAX) ? hdlc_dfr_pkg::COUNT_MAX
                                                              : limit_ext;
    assign count_ext = hdlc_dfr_pkg::CMP_W'(i_state.count);
    assign data_byte = i_state.esc ? (i_line_byte ^ hdlc_dfr_pkg::ESC_XOR) : i_line_byte;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_kind == hdlc_dfr_pkg::KIND_DROP) begin
            o_state = '0;
        end else if (i_line_byte == hdlc_dfr_pkg::FLAG_BYTE) begin
            // close any open non-empty frame, then open a fresh one
            if (i_state.in_frame && (i_state.count != '0)) begin
                o_result.valid        = 1'b1;
                o_result.event_res    = i_cfg.sink_attached ? hdlc_dfr_pkg::EV_DONE
                                                            : hdlc_dfr_pkg::EV_DISCARD;
                o_result.frame_length = count_ext[hdlc_dfr_pkg::LEN_W-1:0];
            end
            o_state.count    = '0;
            o_state.in_frame = 1'b1;
            o_state.esc      = 1'b0;
        end else if (!i_state.in_frame) begin
            o_state = i_state;
        end else if (i_line_byte == hdlc_dfr_pkg::ESC_BYTE) begin
            o_state.esc = 1'b1;
        end else if (count_ext < limit_sat) begin
            o_state.esc           = 1'b0;
            o_state.count         = i_state.count + 1'b1;
            o_result.valid        = 1'b1;
            o_result.event_res    = hdlc_dfr_pkg::EV_DATA;
            o_result.payload_byte = data_byte;
        end else begin
            // oversize: drop the frame and wait for the next flag
            o_state            = '0;
            o_result.valid     = 1'b1;
            o_result.event_res = hdlc_dfr_pkg::EV_ABORT;
        end
    end

endmodule

// ----- hw/rtl/hdlc_byte_stuffing_deframer_unit.sv -----
// HDLC byte-stuffing deframer top level: input register, step logic,
// result register and config registers. Depends on hdlc_dfr_pkg,
// hdlc_dfr_ifs and hdlc_dfr_step.
`timescale 1ns / 1ps

// Usage
//   i_in  : one beat per received line byte (kind 0) or link-drop reset (kind 1).
//   o_out : at most one event beat per input beat: payload byte, frame done
//           with length, oversize abort, or discard when no sink is attached.
//   i_cfg : register writes (0 frame_limit, 1 sink_attached); always ready,
//           write only while no beat is in flight.
// Path: a taken beat sits in the input register, passes the step logic and
//   its event is held in the result register, which drives o_out.
// Throughput: one beat per cycle while o_out is not held, as the step between
//   the input and result registers is combinational.
// Stall: while o_out is held, the result register keeps its beat and the
//   input register fills; i_in.ready drops once both are occupied.
// Reset (synchronous, active low): no frame open, no escape, count zero,
//   frame_limit 508, sink_attached 1, both registers empty.

module hdlc_byte_stuffing_deframer_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hdlc_dfr_in_if.sink           i_in,
    hdlc_dfr_out_if.source        o_out,
    hdlc_dfr_cfg_if.sink          i_cfg
);

    logic                   r_in_valid;
    logic                   r_in_kind;
    logic [7:0]             r_in_byte;
    hdlc_dfr_pkg::t_state   r_state;
    hdlc_dfr_pkg::t_state   n_state;
    hdlc_dfr_pkg::t_cfg     r_cfg;
    hdlc_dfr_pkg::t_result  n_result;
    hdlc_dfr_pkg::t_result  r_result;

    logic out_free;
    logic fire;
    logic in_accept;

    assign out_free  = !r_result.valid || o_out.ready;
    assign fire      = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    hdlc_dfr_step u_step (
        .i_kind      (r_in_kind),
        .i_line_byte (r_in_byte),
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_kind <= i_in.kind;
            r_in_byte <= i_in.line_byte;
        end
    end

    // deframer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= '0;
            r_result.valid <= 1'b0;
        end else if (fire) begin
            r_state        <= n_state;
            r_result.valid <= n_result.valid;
        end else if (o_out.ready) begin
            r_result.valid <= 1'b0;
        end
        if (fire) begin
            r_result.event_res    <= n_result.event_res;
            r_result.payload_byte <= n_result.payload_byte;
            r_result.frame_length <= n_result.frame_length;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_limit   <= hdlc_dfr_pkg::LIMIT_RESET;
            r_cfg.sink_attached <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                hdlc_dfr_pkg::REG_FRAME_LIMIT: r_cfg.frame_limit   <= i_cfg.data;
                hdlc_dfr_pkg::REG_SINK:        r_cfg.sink_attached <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid        = r_result.valid;
    assign o_out.event_res    = r_result.event_res;
    assign o_out.payload_byte = r_result.payload_byte;
    assign o_out.frame_length = r_result.frame_length;

    a_abort_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.event_res == hdlc_dfr_pkg::EV_ABORT)
            |-> (o_out.frame_length == '0 && o_out.payload_byte == '0))
        else $error("abort event carries data");

    a_drop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_kind == hdlc_dfr_pkg::KIND_DROP)
            |=> (!r_state.in_frame && !r_state.esc && r_state.count == '0
                 && !r_result.valid))
        else $error("link drop left assembly state");

    a_data_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_result.valid && n_result.event_res == hdlc_dfr_pkg::EV_DATA)
            |=> (r_state.count == $past(r_state.count) + 1'b1))
        else $error("payload beat without count advance");

endmodule

// ----- dv/tb_hdlc_byte_stuffing_deframer_unit.sv -----
`timescale 1ns / 1ps
// Testbench for hdlc_byte_stuffing_deframer_unit: feeds stuffed line bytes and link drops,
// predicts every payload, done, abort and discard beat, and checks the event stream.
// Depends on hdlc_dfr_pkg, hdlc_dfr_ifs and the deframer RTL.

module tb_hdlc_byte_stuffing_deframer_unit;
    import hdlc_dfr_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 4;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_AT_BEAT = 150;
    localparam int HOLD_CYCLES  = 64;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
    } t_line_item;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] frame_length;
    } t_deframe_evt;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic rst_done;
    logic steady;

    hdlc_dfr_in_if  in_if ();
    hdlc_dfr_out_if out_if ();
    hdlc_dfr_cfg_if cfg_if ();

    hdlc_byte_stuffing_deframer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // deframer state and register copies
    logic               in_frame_m;
    logic               esc_m;
    logic [COUNT_W-1:0] count_m;
    logic [LEN_W-1:0]   limit_m;
    logic               sink_m;

    t_line_item   line_q[$];
    t_deframe_evt deframe_exp_q[$];

    int   fail_cnt;
    int   beats_seen;
    int   cycle_cnt;
    int   items_pushed;
    int   hold_left;
    logic held;
    logic in_taken;
    logic cfg_taken;

    always #5 i_clk = ~i_clk;

    function automatic logic idle_now();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic void predict_deframe(input logic kind, input logic [7:0] raw);
        logic [7:0]         b;
        logic [COUNT_W-1:0] lim;
        b   = raw;
        lim = (CMP_W'(limit_m) > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : COUNT_W'(limit_m);
        if (kind == KIND_DROP) begin
            in_frame_m = 1'b0;
            esc_m      = 1'b0;
            count_m    = '0;
        end else if (b == FLAG_BYTE) begin
            if (in_frame_m && count_m != 0)
                deframe_exp_q.insert(deframe_exp_q.size(),
                    t_deframe_evt'{sink_m ? EV_DONE : EV_DISCARD, 8'h00,
                                   LEN_W'(count_m)});
            count_m    = '0;
            in_frame_m = 1'b1;
            esc_m      = 1'b0;
        end else if (in_frame_m) begin
            if (b == ESC_BYTE) begin
                esc_m = 1'b1;
            end else begin
                if (esc_m) begin
                    b     = b ^ ESC_XOR;
                    esc_m = 1'b0;
                end
                if (count_m < lim) begin
                    count_m = count_m + 1'b1;
                    deframe_exp_q.insert(deframe_exp_q.size(),
                                         t_deframe_evt'{EV_DATA, b, '0});
                end else begin
                    // oversize: drop the frame and wait for the next flag
                    count_m    = '0;
                    in_frame_m = 1'b0;
                    esc_m      = 1'b0;
                    deframe_exp_q.insert(deframe_exp_q.size(),
                                         t_deframe_evt'{EV_ABORT, 8'h00, '0});
                end
            end
        end
    endfunction

    // accept, predict and check at the rising edge
    always @(posedge i_clk) begin : monitor
        t_deframe_evt want;
        in_taken  <= in_if.valid && in_if.ready;
        cfg_taken <= cfg_if.valid && cfg_if.ready;
        if (rst_done) begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == REG_FRAME_LIMIT)
                    limit_m = cfg_if.data;
                else if (cfg_if.index == REG_SINK)
                    sink_m = cfg_if.data[0];
            end
            if (in_if.valid && in_if.ready)
                predict_deframe(in_if.kind, in_if.line_byte);
            if (out_if.valid && out_if.ready) begin
                beats_seen <= beats_seen + 1;
                if (deframe_exp_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual event %0d byte %02h len %0d",
                             $time, out_if.event_res, out_if.payload_byte,
                             out_if.frame_length);
                    fail_cnt++;
                end else begin
                    want = deframe_exp_q.pop_front();
                    if (out_if.event_res !== want.event_res) begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, want.event_res, out_if.event_res);
                        fail_cnt++;
                    end
                    if (out_if.payload_byte !== want.payload_byte) begin
                        $display("%0t: payload_byte expected %02h actual %02h",
                                 $time, want.payload_byte, out_if.payload_byte);
                        fail_cnt++;
                    end
                    if (out_if.frame_length !== want.frame_length) begin
                        $display("%0t: frame_length expected %0d actual %0d",
                                 $time, want.frame_length, out_if.frame_length);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // line byte driver: hold the beat until it is taken
    always @(negedge i_clk) begin : line_driver
        t_line_item nxt;
        if (rst_done && (!in_if.valid || in_taken)) begin
            if (line_q.size() != 0 && !idle_now()) begin
                nxt = line_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.kind      <= nxt.kind;
                in_if.line_byte <= nxt.line_byte;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // event receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin : event_ready
        if (rst_done) begin
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else if (!held && beats_seen >= HOLD_AT_BEAT) begin
                held         <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !idle_now();
            end
        end
    end

    task automatic push_item(input logic kind, input logic [7:0] b);
        line_q.insert(line_q.size(), t_line_item'{kind, b});
        items_pushed++;
    endtask

    task automatic push_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            push_item(KIND_LINE, bytes[i]);
    endtask

    function automatic logic [7:0] rand_byte();
        logic [7:0] picks[6];
        picks = '{FLAG_BYTE, ESC_BYTE, 8'h5E, 8'h5D, 8'h00, 8'hFF};
        if ($urandom_range(0, 3) == 0)
            return picks[$urandom_range(0, 5)];
        return 8'($urandom_range(0, 255));
    endfunction

    // open flag, stuffed payload, sometimes a closing flag
    task automatic push_frame(input int n);
        logic [7:0] b;
        push_item(KIND_LINE, FLAG_BYTE);
        for (int i = 0; i < n; i++) begin
            b = rand_byte();
            if (b == FLAG_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0) begin
                push_item(KIND_LINE, ESC_BYTE);
                if ($urandom_range(0, 3) == 0)
                    push_item(KIND_LINE, ESC_BYTE);
                push_item(KIND_LINE, b ^ ESC_XOR);
            end else begin
                push_item(KIND_LINE, b);
            end
        end
        if ($urandom_range(0, 3) != 0)
            push_item(KIND_LINE, FLAG_BYTE);
    endtask

    task automatic run_random(input int n_items);
        int start;
        int sel;
        int n;
        int lim;
        start = items_pushed;
        lim   = int'(limit_m);
        while (items_pushed - start < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                if (lim <= 37 && $urandom_range(0, 3) == 0)
                    n = lim + $urandom_range(0, 2);
                else
                    n = $urandom_range(0, (lim < 24) ? lim : 24);
                push_frame(n);
            end else if (sel < 92) begin
                repeat ($urandom_range(1, 4))
                    push_item(KIND_LINE, 8'($urandom_range(0, 255)));
            end else if (sel < 96) begin
                push_item(KIND_DROP, 8'($urandom_range(0, 255)));
            end else begin
                // broken frame: cut by a link drop or by a flag after an escape
                push_item(KIND_LINE, FLAG_BYTE);
                repeat ($urandom_range(0, 3))
                    push_item(KIND_LINE, rand_byte());
                if ($urandom_range(0, 1) == 0) begin
                    push_item(KIND_DROP, 8'($urandom_range(0, 255)));
                end else begin
                    push_item(KIND_LINE, ESC_BYTE);
                    push_item(KIND_LINE, FLAG_BYTE);
                end
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_if.valid <= 1'b0;
    endtask

    // wait until every beat is sent and checked, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (line_q.size() != 0 || in_if.valid || deframe_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        rst_done         = 1'b0;
        steady           = 1'b0;
        in_if.valid      = 1'b0;
        in_if.kind       = KIND_LINE;
        in_if.line_byte  = 8'h00;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_FRAME_LIMIT;
        cfg_if.data      = '0;
        in_frame_m       = 1'b0;
        esc_m            = 1'b0;
        count_m          = '0;
        limit_m          = LIMIT_RESET;
        sink_m           = 1'b1;
        fail_cnt         = 0;
        beats_seen       = 0;
        cycle_cnt        = 0;
        items_pushed     = 0;
        hold_left        = 0;
        held             = 1'b0;
        in_taken         = 1'b0;
        cfg_taken        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        // reset settings: ignored bytes, empty frame, escapes, link drops
        push_bytes('{8'h00, ESC_BYTE, FLAG_BYTE, FLAG_BYTE, 8'h00, 8'hFF,
                     ESC_BYTE, 8'h5E, ESC_BYTE, ESC_BYTE, 8'h5D, FLAG_BYTE,
                     8'h41, ESC_BYTE, FLAG_BYTE});
        push_item(KIND_DROP, FLAG_BYTE);
        push_bytes('{8'h55, FLAG_BYTE, 8'hA5});
        push_item(KIND_DROP, 8'h00);
        push_bytes('{FLAG_BYTE});
        wait_drained();

        // short limit with no sink: oversize abort and discard
        write_reg(REG_FRAME_LIMIT, 12'd3);
        write_reg(REG_SINK, 12'd0);
        push_bytes('{FLAG_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, FLAG_BYTE,
                     8'h11, FLAG_BYTE});
        wait_drained();

        // zero limit: first payload byte aborts
        write_reg(REG_FRAME_LIMIT, 12'd0);
        write_reg(REG_SINK, 12'd1);
        push_bytes('{FLAG_BYTE, ESC_BYTE, 8'h33, FLAG_BYTE, FLAG_BYTE});
        wait_drained();

        write_reg(REG_FRAME_LIMIT, 12'hFFF);
        run_random(100);
        wait_drained();

        write_reg(REG_FRAME_LIMIT, 12'd1);
        write_reg(REG_SINK, 12'd0);
        run_random(80);
        wait_drained();

        write_reg(REG_FRAME_LIMIT, LEN_W'($urandom_range(2, 30)));
        write_reg(REG_SINK, 12'd1);
        steady = 1'b1;
        run_random(100);
        wait_drained();
        steady = 1'b0;

        write_reg(REG_FRAME_LIMIT, LIMIT_RESET);
        write_reg(REG_SINK, LEN_W'($urandom_range(0, 1)));
        run_random(100);
        wait_drained();

        write_reg(REG_FRAME_LIMIT, LEN_W'($urandom_range(0, 12)));
        write_reg(REG_SINK, 12'd1);
        run_random(90);
        wait_drained();

        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
